>>> hdl/ocvm_pkg.sv
// ----------------------------------------------------------------------------
// ocvm_pkg
// widths, latencies and shared types of the orbit camera view matrix engine
// ----------------------------------------------------------------------------
package ocvm_pkg;

    // rotated axis component, wide q2.14
    localparam int AX_W       = 20;
    // vector component entering a normalizer, wide q2.14
    localparam int V_W        = 21;
    // normalized component, q2.14
    localparam int N_W        = 16;
    // square of one component and the sum of three squares
    localparam int SQ_W       = 2 * V_W - 1;
    localparam int SS_W       = SQ_W + 1;
    // square root radicand (sum scaled by 2^20) and root width
    localparam int RAD_PAD    = 20;
    localparam int RAD_W      = SS_W + RAD_PAD;
    localparam int ROOT_W     = RAD_W / 2;
    // quotient bits and dividend width of the per-lane divider
    localparam int QUO_W      = N_W - 1;
    localparam int NUM_W      = ROOT_W + QUO_W;
    localparam int NORM_SHIFT = 24;
    // normalizer latency: square, sum, root steps, setup, divide steps, sign
    localparam int NORM_LAT   = ROOT_W + QUO_W + 4;

    // eye position, wide q16.16, and its split for the dot products
    localparam int EYE_W      = 37;
    localparam int EYE_LO     = 19;
    localparam int DOT_W      = 56;

    // side data delay lines around the two normalizers
    localparam int DLY1       = NORM_LAT - 1;
    localparam int DLY2       = NORM_LAT + 1;

    typedef logic signed [V_W-1:0] t_vin;
    typedef logic signed [N_W-1:0] t_nout;

endpackage

>>> hdl/ocvm_norm.sv
// ----------------------------------------------------------------------------
// ocvm_norm
// pipelined vector normalizer: sum of squares, one root bit per stage,
// then one quotient bit per stage for each of the three lanes
// ----------------------------------------------------------------------------
module ocvm_norm
    import ocvm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_vin  i_v [3],
    output logic  o_valid,
    output t_nout o_n [3]
);

    typedef struct packed {
        logic [RAD_W-1:0]          rad;
        logic [ROOT_W+1:0]         rem;
        logic [ROOT_W-1:0]         root;
        logic                      zero;
        logic [2:0]                neg;
        logic [2:0][V_W-1:0]       mag;
    } t_sq_st;

    typedef struct packed {
        logic [ROOT_W-1:0]         len;
        logic [2:0][ROOT_W-1:0]    rem;
        logic [2:0][QUO_W-1:0]     low;
        logic [2:0][QUO_W-1:0]     quo;
        logic                      zero;
        logic [2:0]                neg;
    } t_dv_st;

    // squares, magnitudes and signs
    logic                      r_sq_v;
    logic [SQ_W-1:0]           r_sq [3];
    logic [2:0][V_W-1:0]       r_mag;
    logic [2:0]                r_neg;
    logic signed [2*V_W-1:0]   sq_prod [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_prod[i] = i_v[i] * i_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else if (i_en) begin
            r_sq_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i]  <= sq_prod[i][SQ_W-1:0];
                r_neg[i] <= i_v[i][V_W-1];
                r_mag[i] <= i_v[i][V_W-1] ? V_W'(-i_v[i]) : i_v[i];
            end
        end
    end

    // sum of squares loads the root pipeline
    logic [ROOT_W:0] r_sq_vld;
    t_sq_st          r_sq_st [ROOT_W+1];
    t_sq_st          n_sq    [ROOT_W];
    logic [SS_W-1:0] sum_sq;

    assign sum_sq = SS_W'(r_sq[0]) + SS_W'(r_sq[1]) + SS_W'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_sq_vld[0] <= r_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_st[0].rad  <= {sum_sq, {RAD_PAD{1'b0}}};
            r_sq_st[0].rem  <= '0;
            r_sq_st[0].root <= '0;
            r_sq_st[0].zero <= (sum_sq == '0);
            r_sq_st[0].neg  <= r_neg;
            r_sq_st[0].mag  <= r_mag;
        end
    end

    // integer square root, one root bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        logic [ROOT_W+1:0] cur;
        logic [ROOT_W+1:0] trial;

        assign cur   = {r_sq_st[k].rem[ROOT_W-1:0], r_sq_st[k].rad[RAD_W-1 -: 2]};
        assign trial = {r_sq_st[k].root, 2'b01};

        always_comb begin
            n_sq[k]     = r_sq_st[k];
            n_sq[k].rad = r_sq_st[k].rad << 2;
            if (cur >= trial) begin
                n_sq[k].rem  = cur - trial;
                n_sq[k].root = {r_sq_st[k].root[ROOT_W-2:0], 1'b1};
            end else begin
                n_sq[k].rem  = cur;
                n_sq[k].root = {r_sq_st[k].root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_st[k+1] <= n_sq[k];
            end
        end
    end

    // divider setup: magnitude scaled by 2^24 plus half the length
    logic [QUO_W:0]   r_dv_vld;
    t_dv_st           r_dv_st [QUO_W+1];
    t_dv_st           n_dv    [QUO_W];
    logic [NUM_W-1:0] num [3];
    t_sq_st           root_st;

    assign root_st = r_sq_st[ROOT_W];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = (NUM_W'(root_st.mag[i]) << NORM_SHIFT) + NUM_W'(root_st.root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_vld[0] <= r_sq_vld[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_st[0].len  <= root_st.root;
            r_dv_st[0].zero <= root_st.zero;
            r_dv_st[0].neg  <= root_st.neg;
            for (int i = 0; i < 3; i++) begin
                r_dv_st[0].rem[i] <= num[i][NUM_W-1:QUO_W];
                r_dv_st[0].low[i] <= num[i][QUO_W-1:0];
                r_dv_st[0].quo[i] <= '0;
            end
        end
    end

    // restoring division, one quotient bit per stage in each lane
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        always_comb begin
            logic [ROOT_W:0] cur;
            logic [ROOT_W:0] den;
            n_dv[k] = r_dv_st[k];
            den     = {1'b0, r_dv_st[k].len};
            for (int i = 0; i < 3; i++) begin
                cur = {r_dv_st[k].rem[i], r_dv_st[k].low[i][QUO_W-1]};
                n_dv[k].low[i] = r_dv_st[k].low[i] << 1;
                if (cur >= den) begin
                    n_dv[k].rem[i] = ROOT_W'(cur - den);
                    n_dv[k].quo[i] = {r_dv_st[k].quo[i][QUO_W-2:0], 1'b1};
                end else begin
                    n_dv[k].rem[i] = cur[ROOT_W-1:0];
                    n_dv[k].quo[i] = {r_dv_st[k].quo[i][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_st[k+1] <= n_dv[k];
            end
        end
    end

    // sign restore, zero vector gives zero
    logic  r_out_v;
    t_nout r_out [3];
    t_nout qmag  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qmag[i] = {1'b0, r_dv_st[QUO_W].quo[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_dv_vld[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dv_st[QUO_W].zero) begin
                    r_out[i] <= '0;
                end else if (r_dv_st[QUO_W].neg[i]) begin
                    r_out[i] <= -qmag[i];
                end else begin
                    r_out[i] <= qmag[i];
                end
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_n     = r_out;

endmodule

>>> hdl/orbit_camera_view_matrix.sv
// ----------------------------------------------------------------------------
// orbit_camera_view_matrix
// throughput: one camera per cycle while the result register is not held;
// the latency is set mostly by the two normalizers,
// each a 31-stage square root followed by a 15-stage divider
// reset: synchronous active-low, clears the valid bits; no clearing pass
// ----------------------------------------------------------------------------
module orbit_camera_view_matrix
    import ocvm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // orbit_distance[30:0], target_x[62:31], target_y[94:63], target_z[126:95],
    // rot_w[142:127], rot_x[158:143], rot_y[174:159], rot_z[190:175], zero pad
    input  logic [191:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // right_x/y/z[47:0], upward_x/y/z[95:48], back_x/y/z[143:96],
    // shift_x[175:144], shift_y[207:176], shift_z[239:208]
    output logic [239:0] o_m_tdata
);

    typedef struct packed {
        logic [2:0][AX_W-1:0]  ry;
        logic [2:0][EYE_W-1:0] eye;
    } t_side1;

    typedef struct packed {
        logic [2:0][N_W-1:0]   fwd;
        logic [2:0][EYE_W-1:0] eye;
    } t_side2;

    logic en;
    logic r_out_v;

    // whole pipeline advances unless the result register is held
    assign en         = !r_out_v || i_m_tready;
    assign o_s_tready = en;

    // stage 1: input register, zero distance raised to one lsb
    logic               r1_v;
    logic [30:0]        r1_d;
    logic signed [31:0] r1_t [3];
    logic signed [15:0] r1_w, r1_x, r1_y, r1_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d    <= (i_s_tdata[30:0] == '0) ? 31'd1 : i_s_tdata[30:0];
            r1_t[0] <= $signed(i_s_tdata[62:31]);
            r1_t[1] <= $signed(i_s_tdata[94:63]);
            r1_t[2] <= $signed(i_s_tdata[126:95]);
            r1_w    <= $signed(i_s_tdata[142:127]);
            r1_x    <= $signed(i_s_tdata[158:143]);
            r1_y    <= $signed(i_s_tdata[174:159]);
            r1_z    <= $signed(i_s_tdata[190:175]);
        end
    end

    // stage 2: quaternion products
    logic               r2_v;
    logic [30:0]        r2_d;
    logic signed [31:0] r2_t [3];
    logic signed [31:0] r2_zx, r2_wy, r2_wx, r2_zy, r2_ww;
    logic signed [31:0] r2_zz, r2_wz, r2_yx, r2_yy, r2_yz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_d  <= r1_d;
            r2_t  <= r1_t;
            r2_zx <= r1_z * r1_x;
            r2_wy <= r1_w * r1_y;
            r2_wx <= r1_w * r1_x;
            r2_zy <= r1_z * r1_y;
            r2_ww <= r1_w * r1_w;
            r2_zz <= r1_z * r1_z;
            r2_wz <= r1_w * r1_z;
            r2_yx <= r1_y * r1_x;
            r2_yy <= r1_y * r1_y;
            r2_yz <= r1_y * r1_z;
        end
    end

    // stage 3: rotated z and y axes, rounded to wide q2.14
    logic                  r3_v;
    logic [30:0]           r3_d;
    logic signed [31:0]    r3_t  [3];
    logic signed [AX_W-1:0] r3_rz [3];
    logic signed [AX_W-1:0] r3_ry [3];
    logic signed [34:0]    w_rz [3];
    logic signed [34:0]    w_ry [3];

    always_comb begin
        w_rz[0] = ((35'(r2_zx) - 35'(r2_wy)) <<< 1) + 35'sd8192;
        w_rz[1] = ((35'(r2_wx) + 35'(r2_zy)) <<< 1) + 35'sd8192;
        w_rz[2] = ((35'(r2_ww) + 35'(r2_zz)) <<< 1) - 35'sd268435456 + 35'sd8192;
        w_ry[0] = ((35'(r2_wz) + 35'(r2_yx)) <<< 1) + 35'sd8192;
        w_ry[1] = ((35'(r2_ww) + 35'(r2_yy)) <<< 1) - 35'sd268435456 + 35'sd8192;
        w_ry[2] = ((35'(r2_yz) - 35'(r2_wx)) <<< 1) + 35'sd8192;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_d <= r2_d;
            r3_t <= r2_t;
            for (int i = 0; i < 3; i++) begin
                r3_rz[i] <= $signed(w_rz[i][AX_W+13:14]);
                r3_ry[i] <= $signed(w_ry[i][AX_W+13:14]);
            end
        end
    end

    // first normalizer: forward is the normalized negated z axis
    t_vin  n1_v [3];
    t_nout n1_n [3];
    logic  n1_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_v[i] = -(V_W'(r3_rz[i]));
        end
    end

    ocvm_norm u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_v     (n1_v),
        .o_valid (n1_valid),
        .o_n     (n1_n)
    );

    // stage 4: distance times rotated z
    logic signed [31:0]     r4_t  [3];
    logic signed [AX_W-1:0] r4_ry [3];
    logic signed [51:0]     r4_dz [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_t  <= r3_t;
            r4_ry <= r3_ry;
            for (int i = 0; i < 3; i++) begin
                r4_dz[i] <= $signed({1'b0, r3_d}) * r3_rz[i];
            end
        end
    end

    // stage 5: eye position, then delayed alongside the first normalizer
    t_side1             r_d1 [DLY1];
    t_side1             w_s1;
    logic signed [52:0] w_dz [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dz[i]       = 53'(r4_dz[i]) + 53'sd8192;
            w_s1.ry[i]    = r4_ry[i];
            w_s1.eye[i]   = EYE_W'(r4_t[i]) + $signed(w_dz[i][EYE_W+13:14]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1[0] <= w_s1;
            for (int k = 1; k < DLY1; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
        end
    end

    // stage 6: products of forward cross rotated y
    logic                  r6_v;
    t_nout                 r6_f [3];
    logic [2:0][EYE_W-1:0] r6_eye;
    logic signed [35:0]    r6_p [6];
    logic signed [AX_W-1:0] ry1 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ry1[i] = $signed(r_d1[DLY1-1].ry[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= n1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_f    <= n1_n;
            r6_eye  <= r_d1[DLY1-1].eye;
            r6_p[0] <= n1_n[1] * ry1[2];
            r6_p[1] <= n1_n[2] * ry1[1];
            r6_p[2] <= n1_n[2] * ry1[0];
            r6_p[3] <= n1_n[0] * ry1[2];
            r6_p[4] <= n1_n[0] * ry1[1];
            r6_p[5] <= n1_n[1] * ry1[0];
        end
    end

    // stage 7: rounded cross product, delayed side data for the second normalizer
    logic               r7_v;
    t_vin               r7_rc [3];
    t_side2             r_d2 [DLY2];
    t_side2             w_s2;
    logic signed [36:0] w_rc [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rc[i] = 37'(r6_p[2*i]) - 37'(r6_p[2*i+1]) + 37'sd8192;
            w_s2.fwd[i] = r6_f[i];
        end
        w_s2.eye = r6_eye;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r7_rc[i] <= $signed(w_rc[i][V_W+13:14]);
            end
            r_d2[0] <= w_s2;
            for (int k = 1; k < DLY2; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    // second normalizer: right axis
    t_nout n2_n [3];
    logic  n2_valid;

    ocvm_norm u_norm_rgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_v     (r7_rc),
        .o_valid (n2_valid),
        .o_n     (n2_n)
    );

    // stage 8: products of right cross forward
    logic                  r8_v;
    t_nout                 r8_r [3];
    t_nout                 r8_f [3];
    logic [2:0][EYE_W-1:0] r8_eye;
    logic signed [31:0]    r8_p [6];
    t_nout                 f2 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f2[i] = $signed(r_d2[DLY2-1].fwd[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= n2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_r    <= n2_n;
            r8_f    <= f2;
            r8_eye  <= r_d2[DLY2-1].eye;
            r8_p[0] <= n2_n[1] * f2[2];
            r8_p[1] <= n2_n[2] * f2[1];
            r8_p[2] <= n2_n[2] * f2[0];
            r8_p[3] <= n2_n[0] * f2[2];
            r8_p[4] <= n2_n[0] * f2[1];
            r8_p[5] <= n2_n[1] * f2[0];
        end
    end

    // stage 9: rounded up axis
    logic                  r9_v;
    t_nout                 r9_r [3];
    t_nout                 r9_f [3];
    logic signed [16:0]    r9_u [3];
    logic [2:0][EYE_W-1:0] r9_eye;
    logic signed [32:0]    w_up [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_up[i] = 33'(r8_p[2*i]) - 33'(r8_p[2*i+1]) + 33'sd8192;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_r   <= r8_r;
            r9_f   <= r8_f;
            r9_eye <= r8_eye;
            for (int i = 0; i < 3; i++) begin
                r9_u[i] <= $signed(w_up[i][30:14]);
            end
        end
    end

    // stage 10: dot partial products on split eye, rotation entries finalized
    logic               r10_v;
    logic signed [36:0] r10_pl [3][3];
    logic signed [34:0] r10_ph [3][3];
    logic [15:0]        r10_rot [9];
    logic signed [16:0] vec [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vec[0][i] = 17'(r9_r[i]);
            vec[1][i] = r9_u[i];
            vec[2][i] = 17'(r9_f[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (en) begin
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r10_pl[j][i] <= vec[j][i] * $signed({1'b0, r9_eye[i][EYE_LO-1:0]});
                    r10_ph[j][i] <= vec[j][i] * $signed(r9_eye[i][EYE_W-1:EYE_LO]);
                end
            end
            for (int i = 0; i < 3; i++) begin
                r10_rot[i] <= r9_r[i];
                if (r9_u[i][16] != r9_u[i][15]) begin
                    r10_rot[3+i] <= r9_u[i][16] ? 16'h8000 : 16'h7fff;
                end else begin
                    r10_rot[3+i] <= r9_u[i][15:0];
                end
                r10_rot[6+i] <= -r9_f[i];
            end
        end
    end

    // stage 11: full products
    logic               r11_v;
    logic signed [DOT_W-1:0] r11_full [3][3];
    logic [15:0]        r11_rot [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else if (en) begin
            r11_v <= r10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_rot <= r10_rot;
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r11_full[j][i] <= (DOT_W'(r10_ph[j][i]) <<< EYE_LO)
                                    + DOT_W'(r10_pl[j][i]);
                end
            end
        end
    end

    // stage 12: dot sums, right and up negated
    logic                    r12_v;
    logic signed [DOT_W-1:0] r12_s [3];
    logic [15:0]             r12_rot [9];
    logic signed [DOT_W-1:0] dsum [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            dsum[j] = r11_full[j][0] + r11_full[j][1] + r11_full[j][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_v <= 1'b0;
        end else if (en) begin
            r12_v <= r11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_rot  <= r11_rot;
            r12_s[0] <= -dsum[0];
            r12_s[1] <= -dsum[1];
            r12_s[2] <= dsum[2];
        end
    end

    // stage 13: round to q16.16, saturate, result register
    logic [239:0]            r_out_data;
    logic signed [DOT_W-1:0] w_rs [3];
    logic [31:0]             w_sh [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_rs[j] = (r12_s[j] + DOT_W'(8192)) >>> 14;
            if (w_rs[j][DOT_W-1:31] == '0 || w_rs[j][DOT_W-1:31] == '1) begin
                w_sh[j] = w_rs[j][31:0];
            end else begin
                w_sh[j] = w_rs[j][DOT_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r12_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {w_sh[2], w_sh[1], w_sh[0],
                           r12_rot[8], r12_rot[7], r12_rot[6],
                           r12_rot[5], r12_rot[4], r12_rot[3],
                           r12_rot[2], r12_rot[1], r12_rot[0]};
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;

endmodule

>>> hdl/ocvm_checker.sv
// ----------------------------------------------------------------------------
// ocvm_checker
// port-level checks of the view matrix engine, bound to the top level
// ----------------------------------------------------------------------------
module ocvm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [191:0] i_s_tdata,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [239:0] o_m_tdata
);

    // a held result keeps its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // with no result pending the input side is open
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // right_x and back_z never exceed one in magnitude
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            $signed(o_m_tdata[15:0]) >= -16'sd16384 &&
            $signed(o_m_tdata[15:0]) <= 16'sd16384 &&
            $signed(o_m_tdata[143:128]) >= -16'sd16384 &&
            $signed(o_m_tdata[143:128]) <= 16'sd16384)
        else $error("axis entry beyond unit length");

endmodule

bind orbit_camera_view_matrix ocvm_checker u_ocvm_checker (.*);
